// ===== hdl/ewpc_pkg.sv =====
// Types and constants shared by the edge window period capture block.
package ewpc_pkg;

    localparam int unsigned CaptureW   = 16;
    localparam int unsigned OvfW       = 7;
    localparam int unsigned WinW       = 8;
    localparam int unsigned CfgIdxW    = 2;
    localparam int unsigned CfgDataW   = 16;

    localparam logic [OvfW-1:0]     OvfMax          = 7'h7F;
    localparam logic [CaptureW-1:0] EdgesResetVal   = 16'd32768;
    localparam logic [WinW-1:0]     WindowsResetVal = 8'd16;

    localparam logic [CfgIdxW-1:0] CfgEdgesPerWindow = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgWindowsToRun   = 2'd1;

    localparam logic OpEdge     = 1'b0;
    localparam logic OpOverflow = 1'b1;

    typedef struct packed {
        logic                op;
        logic [CaptureW-1:0] capture_value;
    } t_in_item;

    typedef struct packed {
        logic [CaptureW-1:0] start_capture;
        logic [CaptureW-1:0] end_capture;
        logic [OvfW-1:0]     overflow_count;
        logic                overflow_saturated;
        logic [WinW-1:0]     window_index;
        logic                last;
    } t_out_item;

endpackage

// ===== hdl/ewpc_if.sv =====
// Valid/ready channel interfaces for event beats and window record beats.
interface ewpc_in_if import ewpc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ewpc_out_if import ewpc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/edge_window_period_capture_unit.sv =====
// Edge window period capture unit: top level.
//
// Takes one event beat per cycle (rising edge with timer capture, or timer
// overflow) and emits one record per completed window of edges_per_window
// edges, holding start and end captures, the overflow count saturated at
// 127 with its flag, the window index and a last mark. Each event is
// handled in the cycle it is accepted; a record appears in the output
// register on the next cycle. The input is ready whenever the output
// register is empty or being drained, so the rate is one event per cycle
// while the sink keeps up. After windows_to_run records the block ignores
// all events until reset. Configuration is a plain write port; index 0 is
// edges_per_window, index 1 windows_to_run.
module edge_window_period_capture_unit
    import ewpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    ewpc_in_if.sink             i_in,
    ewpc_out_if.source          o_out
);

    logic [CaptureW-1:0] r_edges_per_window;
    logic [WinW-1:0]     r_windows_to_run;

    logic                r_window_armed,      n_window_armed;
    logic [OvfW-1:0]     r_overflows_seen,    n_overflows_seen;
    logic                r_overflow_sat_flag, n_overflow_sat_flag;
    logic [CaptureW-1:0] r_edges_seen,        n_edges_seen;
    logic [CaptureW-1:0] r_start_latch,       n_start_latch;
    logic [WinW-1:0]     r_windows_done,      n_windows_done;
    logic                r_calibration_done,  n_calibration_done;

    logic                r_out_valid, n_out_valid;
    t_out_item           r_out,       n_out;

    logic                in_beat;
    logic                emit;
    logic [CaptureW:0]   next_edges;
    logic [WinW:0]       next_done;
    logic                is_last;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_beat     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign next_edges = {1'b0, r_edges_seen} + {{CaptureW{1'b0}}, 1'b1};
    assign next_done  = {1'b0, r_windows_done} + {{WinW{1'b0}}, 1'b1};
    assign is_last    = (next_done >= {1'b0, r_windows_to_run}) || next_done[WinW];

    always_comb begin
        n_window_armed      = r_window_armed;
        n_overflows_seen    = r_overflows_seen;
        n_overflow_sat_flag = r_overflow_sat_flag;
        n_edges_seen        = r_edges_seen;
        n_start_latch       = r_start_latch;
        n_windows_done      = r_windows_done;
        n_calibration_done  = r_calibration_done;
        emit                = 1'b0;

        n_out.start_capture      = r_start_latch;
        n_out.end_capture        = i_in.data.capture_value;
        n_out.overflow_count     = r_overflows_seen;
        n_out.overflow_saturated = r_overflow_sat_flag;
        n_out.window_index       = r_windows_done;
        n_out.last               = is_last;

        if (in_beat && !r_calibration_done) begin
            if (i_in.data.op == OpOverflow) begin
                if (r_window_armed) begin
                    if (r_overflows_seen >= OvfMax) begin
                        n_overflows_seen    = OvfMax;
                        n_overflow_sat_flag = 1'b1;
                    end else begin
                        n_overflows_seen = r_overflows_seen + {{(OvfW-1){1'b0}}, 1'b1};
                    end
                end
            end else if (!r_window_armed) begin
                n_window_armed      = 1'b1;
                n_start_latch       = i_in.data.capture_value;
                n_edges_seen        = {{(CaptureW-1){1'b0}}, 1'b1};
                n_overflows_seen    = '0;
                n_overflow_sat_flag = 1'b0;
            end else if (next_edges < {1'b0, r_edges_per_window}) begin
                n_edges_seen = next_edges[CaptureW-1:0];
            end else begin
                emit                = 1'b1;
                n_window_armed      = 1'b0;
                n_edges_seen        = '0;
                n_overflows_seen    = '0;
                n_overflow_sat_flag = 1'b0;
                if (is_last) begin
                    n_windows_done     = '0;
                    n_calibration_done = 1'b1;
                end else begin
                    n_windows_done = next_done[WinW-1:0];
                end
            end
        end

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edges_per_window  <= EdgesResetVal;
            r_windows_to_run    <= WindowsResetVal;
            r_window_armed      <= 1'b0;
            r_overflows_seen    <= '0;
            r_overflow_sat_flag <= 1'b0;
            r_edges_seen        <= '0;
            r_start_latch       <= '0;
            r_windows_done      <= '0;
            r_calibration_done  <= 1'b0;
            r_out_valid         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CfgEdgesPerWindow: r_edges_per_window <= i_cfg_data;
                    CfgWindowsToRun:   r_windows_to_run   <= i_cfg_data[WinW-1:0];
                    default: ;
                endcase
            end
            r_window_armed      <= n_window_armed;
            r_overflows_seen    <= n_overflows_seen;
            r_overflow_sat_flag <= n_overflow_sat_flag;
            r_edges_seen        <= n_edges_seen;
            r_start_latch       <= n_start_latch;
            r_windows_done      <= n_windows_done;
            r_calibration_done  <= n_calibration_done;
            r_out_valid         <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

endmodule
